// ----- hdl/hjbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hjbd_pkg;

   localparam int unsigned ADC_CODE_W   = 12;
   localparam int unsigned ADC_HIGH_W   = 8;
   localparam int unsigned ADC_LOW_W    = 4;
   localparam int unsigned MV_W         = 11;
   localparam int unsigned THR_CODE_W   = 8;
   localparam int unsigned MV_PRODUCT_W = ADC_CODE_W + MV_W;

   localparam logic [MV_W-1:0] FULL_SCALE_MV = 11'd1400;
   localparam logic [MV_W-1:0] PRESS_LOW_MV  = 11'd8;

   // Millivolts to an ADC threshold code is floor(mv * 32 / 175).
   // The division is a multiplication by ceil(2^24 / 175) and a shift by 24,
   // with the factor 32 folded into the shift.
   localparam int unsigned RECIP_W       = 17;
   localparam int unsigned RECIP_SHIFT   = 19;
   localparam logic [RECIP_W-1:0] CODE_RECIP = 17'd95870;
   localparam int unsigned RECIP_PROD_W  = MV_W + RECIP_W;
   localparam int unsigned RECIP_Q_W     = RECIP_PROD_W - RECIP_SHIFT;

   localparam logic [THR_CODE_W-1:0] THR_CODE_MAX = 8'hFF;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_HOOK_THR       = 3'd0,
      CSR_VOL_UP_THR     = 3'd1,
      CSR_VOL_DOWN_THR   = 3'd2,
      CSR_MIC_DETECT_THR = 3'd3,
      CSR_PRESS_REL_THR  = 3'd4,
      CSR_DETECT_INV     = 3'd5
   } csr_index_type;

   localparam logic [MV_W-1:0] HOOK_THR_RESET       = 11'd20;
   localparam logic [MV_W-1:0] VOL_UP_THR_RESET     = 11'd60;
   localparam logic [MV_W-1:0] VOL_DOWN_THR_RESET   = 11'd110;
   localparam logic [MV_W-1:0] MIC_DETECT_THR_RESET = 11'd300;
   localparam logic [MV_W-1:0] PRESS_REL_THR_RESET  = 11'd300;

   typedef enum logic [1:0] {
      OUTCOME_HANDLED  = 2'd0,
      OUTCOME_INVALID  = 2'd1,
      OUTCOME_FAKE     = 2'd2,
      OUTCOME_IRQ_OFF  = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      JACK_REMOVED   = 2'd0,
      JACK_HEADSET   = 2'd1,
      JACK_HEADPHONE = 2'd2
   } jack_type;

   typedef enum logic [1:0] {
      KEY_NONE     = 2'd0,
      KEY_HOOK     = 2'd1,
      KEY_VOL_UP   = 2'd2,
      KEY_VOL_DOWN = 2'd3
   } key_type;

   typedef enum logic {
      FUNC_JACK   = 1'b0,
      FUNC_BUTTON = 1'b1
   } func_type;

   function automatic logic [THR_CODE_W-1:0] mv_to_code(input logic [MV_W-1:0] mv);
      logic [RECIP_PROD_W-1:0] product;
      logic [RECIP_Q_W-1:0]    quotient;
      product  = RECIP_PROD_W'(mv) * RECIP_PROD_W'(CODE_RECIP);
      quotient = product[RECIP_PROD_W-1:RECIP_SHIFT];
      if (quotient > RECIP_Q_W'(THR_CODE_MAX)) begin
         return THR_CODE_MAX;
      end
      return quotient[THR_CODE_W-1:0];
   endfunction

   localparam logic [THR_CODE_W-1:0] PRESS_LOW_CODE = mv_to_code(PRESS_LOW_MV);

endpackage

`default_nettype wire

// ----- hdl/hjbd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hjbd_req_if;
   import hjbd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  func;
   logic                  detect_pin;
   logic [ADC_HIGH_W-1:0] adc_high_byte;
   logic [ADC_LOW_W-1:0]  adc_low_nibble;

   modport source (output valid, func, detect_pin, adc_high_byte, adc_low_nibble,
                   input ready);
   modport sink (input valid, func, detect_pin, adc_high_byte, adc_low_nibble,
                 output ready);
endinterface

interface hjbd_rsp_if;
   import hjbd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            outcome;
   logic [1:0]            jack_kind;
   logic                  key_valid;
   logic [1:0]            key_code;
   logic                  key_pressed;
   logic                  mic_power_on;
   logic                  threshold_write;
   logic [THR_CODE_W-1:0] low_threshold_code;
   logic [THR_CODE_W-1:0] high_threshold_code;
   logic [MV_W-1:0]       voltage_mv;
   logic                  button_irq_enabled;

   modport source (output valid, outcome, jack_kind, key_valid, key_code, key_pressed,
                   mic_power_on, threshold_write, low_threshold_code,
                   high_threshold_code, voltage_mv, button_irq_enabled,
                   input ready);
   modport sink (input valid, outcome, jack_kind, key_valid, key_code, key_pressed,
                 mic_power_on, threshold_write, low_threshold_code,
                 high_threshold_code, voltage_mv, button_irq_enabled,
                 output ready);
endinterface

`default_nettype wire

// ----- hdl/headset_jack_and_button_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Headset jack and button detector. Each request is a jack event or a button event and
// produces exactly one result, presented from the result register once the request has
// left the input register. One request is accepted every cycle unless the result stalls:
// a request waits in the input register, is classified there by a single pass of compare
// logic against the jack, button and interrupt state, and moves into the result register,
// which updates the state at the same edge so that the next request sees it. A stalled
// result holds the pipeline without losing any request. The user must write the threshold
// registers through the APB port only while no request is in flight; this is not enforced.

module headset_jack_and_button_detector (
   input  wire                              clock,
   input  wire                              reset,
   hjbd_req_if.sink                         req_chan,
   hjbd_rsp_if.source                       rsp_chan,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [hjbd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire  [hjbd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [hjbd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import hjbd_pkg::*;

   logic [MV_W-1:0] hook_thr_ff;
   logic [MV_W-1:0] vol_up_thr_ff;
   logic [MV_W-1:0] vol_down_thr_ff;
   logic [MV_W-1:0] mic_detect_thr_ff;
   logic [MV_W-1:0] press_rel_thr_ff;
   logic            detect_inv_ff;
   logic            csr_write;
   csr_index_type   csr_index;

   logic                  req_valid_ff;
   logic                  req_func_ff;
   logic                  req_pin_ff;
   logic [ADC_HIGH_W-1:0] req_adc_high_ff;
   logic [ADC_LOW_W-1:0]  req_adc_low_ff;

   key_type  button_state_ff, button_state_in;
   jack_type jack_state_ff, jack_state_in;
   logic     irq_on_ff, irq_on_in;

   logic                  rsp_valid_ff;
   outcome_type           outcome_ff, outcome_in;
   jack_type              jack_kind_ff;
   logic                  key_valid_ff, key_valid_in;
   key_type               key_code_ff, key_code_in;
   logic                  key_pressed_ff, key_pressed_in;
   logic                  thr_write_ff, thr_write_in;
   logic [THR_CODE_W-1:0] low_code_ff, low_code_in;
   logic [THR_CODE_W-1:0] high_code_ff, high_code_in;
   logic [MV_W-1:0]       volt_ff, volt_in;
   logic                  irq_out_ff;

   logic                    out_advance;
   logic                    step;
   logic                    present;
   logic [ADC_CODE_W-1:0]   adc_code;
   logic [MV_PRODUCT_W-1:0] mv_product;
   logic [MV_W-1:0]         mv;
   logic [THR_CODE_W-1:0]   press_rel_code;
   key_type                 press_key;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         hook_thr_ff       <= HOOK_THR_RESET;
         vol_up_thr_ff     <= VOL_UP_THR_RESET;
         vol_down_thr_ff   <= VOL_DOWN_THR_RESET;
         mic_detect_thr_ff <= MIC_DETECT_THR_RESET;
         press_rel_thr_ff  <= PRESS_REL_THR_RESET;
         detect_inv_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HOOK_THR:       hook_thr_ff       <= pwdata[MV_W-1:0];
            CSR_VOL_UP_THR:     vol_up_thr_ff     <= pwdata[MV_W-1:0];
            CSR_VOL_DOWN_THR:   vol_down_thr_ff   <= pwdata[MV_W-1:0];
            CSR_MIC_DETECT_THR: mic_detect_thr_ff <= pwdata[MV_W-1:0];
            CSR_PRESS_REL_THR:  press_rel_thr_ff  <= pwdata[MV_W-1:0];
            CSR_DETECT_INV:     detect_inv_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_HOOK_THR:       prdata = CSR_DATA_W'(hook_thr_ff);
         CSR_VOL_UP_THR:     prdata = CSR_DATA_W'(vol_up_thr_ff);
         CSR_VOL_DOWN_THR:   prdata = CSR_DATA_W'(vol_down_thr_ff);
         CSR_MIC_DETECT_THR: prdata = CSR_DATA_W'(mic_detect_thr_ff);
         CSR_PRESS_REL_THR:  prdata = CSR_DATA_W'(press_rel_thr_ff);
         CSR_DETECT_INV:     prdata = CSR_DATA_W'(detect_inv_ff);
         default:            prdata = '0;
      endcase
   end

   // Handshake: the input register moves on whenever the result register is free.
   assign out_advance    = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_valid_ff && out_advance;
   assign req_chan.ready = !req_valid_ff || out_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_func_ff     <= req_chan.func;
         req_pin_ff      <= req_chan.detect_pin;
         req_adc_high_ff <= req_chan.adc_high_byte;
         req_adc_low_ff  <= req_chan.adc_low_nibble;
      end
   end

   // Classification of the request in the input register.
   always_comb begin
      present        = req_pin_ff ^ detect_inv_ff;
      adc_code       = {req_adc_high_ff, req_adc_low_ff};
      mv_product     = MV_PRODUCT_W'(adc_code) * MV_PRODUCT_W'(FULL_SCALE_MV);
      mv             = mv_product[MV_PRODUCT_W-1:ADC_CODE_W];
      press_rel_code = mv_to_code(press_rel_thr_ff);

      if (mv < hook_thr_ff) begin
         press_key = KEY_HOOK;
      end else if (mv < vol_up_thr_ff) begin
         press_key = KEY_VOL_UP;
      end else if (mv < vol_down_thr_ff) begin
         press_key = KEY_VOL_DOWN;
      end else begin
         press_key = KEY_NONE;
      end

      button_state_in = button_state_ff;
      jack_state_in   = jack_state_ff;
      irq_on_in       = irq_on_ff;
      outcome_in      = OUTCOME_HANDLED;
      key_valid_in    = 1'b0;
      key_code_in     = KEY_NONE;
      key_pressed_in  = 1'b0;
      thr_write_in    = 1'b0;
      low_code_in     = '0;
      high_code_in    = '0;
      volt_in         = '0;

      if (req_func_ff == FUNC_JACK) begin
         irq_on_in = 1'b0;
         if (present) begin
            volt_in = mv;
            if (mv < mic_detect_thr_ff) begin
               jack_state_in = JACK_HEADPHONE;
            end else begin
               jack_state_in = JACK_HEADSET;
               thr_write_in  = 1'b1;
               low_code_in   = press_rel_code;
               high_code_in  = THR_CODE_MAX;
               irq_on_in     = 1'b1;
            end
         end else begin
            jack_state_in   = JACK_REMOVED;
            button_state_in = KEY_NONE;
         end
      end else if (!irq_on_ff) begin
         outcome_in = OUTCOME_IRQ_OFF;
      end else if (!present) begin
         irq_on_in  = 1'b0;
         outcome_in = OUTCOME_FAKE;
      end else begin
         volt_in = mv;
         if (mv < press_rel_thr_ff) begin
            if (button_state_ff != KEY_NONE || press_key == KEY_NONE) begin
               outcome_in = OUTCOME_INVALID;
            end else begin
               button_state_in = press_key;
               key_valid_in    = 1'b1;
               key_code_in     = press_key;
               key_pressed_in  = 1'b1;
               thr_write_in    = 1'b1;
               low_code_in     = PRESS_LOW_CODE;
               high_code_in    = press_rel_code;
            end
         end else if (button_state_ff == KEY_NONE) begin
            outcome_in = OUTCOME_INVALID;
         end else begin
            key_valid_in    = 1'b1;
            key_code_in     = button_state_ff;
            button_state_in = KEY_NONE;
            thr_write_in    = 1'b1;
            low_code_in     = press_rel_code;
            high_code_in    = THR_CODE_MAX;
         end
      end
   end

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         button_state_ff <= KEY_NONE;
         jack_state_ff   <= JACK_REMOVED;
         irq_on_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (step) begin
            button_state_ff <= button_state_in;
            jack_state_ff   <= jack_state_in;
            irq_on_ff       <= irq_on_in;
         end
         if (out_advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         outcome_ff     <= outcome_in;
         jack_kind_ff   <= jack_state_in;
         key_valid_ff   <= key_valid_in;
         key_code_ff    <= key_code_in;
         key_pressed_ff <= key_pressed_in;
         thr_write_ff   <= thr_write_in;
         low_code_ff    <= low_code_in;
         high_code_ff   <= high_code_in;
         volt_ff        <= volt_in;
         irq_out_ff     <= irq_on_in;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.outcome             = outcome_ff;
   assign rsp_chan.jack_kind           = jack_kind_ff;
   assign rsp_chan.key_valid           = key_valid_ff;
   assign rsp_chan.key_code            = key_code_ff;
   assign rsp_chan.key_pressed         = key_pressed_ff;
   assign rsp_chan.mic_power_on        = (jack_kind_ff == JACK_HEADSET);
   assign rsp_chan.threshold_write     = thr_write_ff;
   assign rsp_chan.low_threshold_code  = low_code_ff;
   assign rsp_chan.high_threshold_code = high_code_ff;
   assign rsp_chan.voltage_mv          = volt_ff;
   assign rsp_chan.button_irq_enabled  = irq_out_ff;

   // A result with the jack removed never leaves the button interrupt enabled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && jack_kind_ff == JACK_REMOVED |-> !irq_out_ff)
      else $error("button interrupt enabled with jack removed");

   // Every reported key comes from a handled request that rewrites the thresholds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && key_valid_ff |-> outcome_ff == OUTCOME_HANDLED && thr_write_ff)
      else $error("key reported without a handled threshold update");

   // A jack removal releases every button.
   assert property (@(posedge clock) disable iff (reset)
      step && req_func_ff == FUNC_JACK && !present |=> button_state_ff == KEY_NONE)
      else $error("button state kept across jack removal");

   // A button is only held while a jack is inserted.
   assert property (@(posedge clock) disable iff (reset)
      button_state_ff != KEY_NONE |-> jack_state_ff != JACK_REMOVED)
      else $error("button held with jack removed");

endmodule

`default_nettype wire
